// ===== src/iida_pkg.sv =====
package iida_pkg;

  // array depth default
  localparam int unsigned Capacity = 128;

  // cells per first-level read group
  localparam int unsigned ReadGroup = 16;

  localparam int unsigned WordW = 32;
  localparam int unsigned PosW  = 8;
  localparam int unsigned CmdW  = 3;
  localparam int unsigned StatW = 2;
  localparam int unsigned FillW = 8;

  typedef enum logic [CmdW-1:0] {
    CMD_CLEAR  = 3'd0,
    CMD_INSERT = 3'd1,
    CMD_EDIT   = 3'd2,
    CMD_DELETE = 3'd3,
    CMD_READ   = 3'd4
  } cmd_e;

  typedef enum logic [StatW-1:0] {
    STAT_OK     = 2'd0,
    STAT_FULL   = 2'd1,
    STAT_BADIDX = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_REDUCE
  } state_e;

  // broadcast control seen by every cell
  typedef struct packed {
    logic            ins;
    logic            del;
    logic            wr;
    logic            rd;
    logic [PosW-1:0] pos;
  } cell_ctrl_t;

endpackage

// ===== src/indexed_insert_delete_array_core.sv =====
// channel  | direction | handshake                 | payload
// command  | in        | in_valid_i / in_ready_o   | cmd_i, position_i, value_i
// result   | out       | out_valid_o / out_ready_i | status_o, read_data_o, fill_count_o
//
// each command passes through the accept (idle) state, the exec state, in which every cell
// shifts or writes in parallel and the first read or level is registered, and the reduce state
// the result is loaded into the output register as the reduce stage is left
// a new command is taken once the previous one has left the reduce stage
// a stalled result holds in the output register; the reduce stage waits for it
// reset clears the fill count and control; cell words are not reset
module indexed_insert_delete_array_core #(
  parameter int unsigned CAPACITY = iida_pkg::Capacity
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [iida_pkg::CmdW-1:0]           cmd_i,
  input  logic [iida_pkg::PosW-1:0]           position_i,
  input  logic signed [iida_pkg::WordW-1:0]   value_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [iida_pkg::StatW-1:0]          status_o,
  output logic signed [iida_pkg::WordW-1:0]   read_data_o,
  output logic [iida_pkg::FillW-1:0]          fill_count_o
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned XW = (CW > iida_pkg::PosW) ? CW : iida_pkg::PosW;
  localparam int unsigned FW = iida_pkg::FillW;
  localparam logic [CW-1:0] CapC = CW'(CAPACITY);

  iida_pkg::state_e state_q, state_d;

  logic [iida_pkg::CmdW-1:0]   cmd_q;
  logic [iida_pkg::PosW-1:0]   pos_q;
  logic [iida_pkg::WordW-1:0]  value_q;
  logic [CW-1:0]               count_q, count_d;
  iida_pkg::status_e           stat_q, stat_d;

  logic                        out_valid_q;
  logic [iida_pkg::StatW-1:0]  out_stat_q;
  logic [iida_pkg::WordW-1:0]  out_data_q;
  logic [iida_pkg::FillW-1:0]  out_fill_q;

  iida_pkg::cell_ctrl_t        ctrl;
  logic [XW-1:0]               pos_x, cnt_x;
  logic                        accept, out_free;
  logic [iida_pkg::WordW-1:0]  red_word;

  logic [CAPACITY-1:0][iida_pkg::WordW-1:0] words, rd_words;

  assign accept   = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;
  assign pos_x    = XW'(pos_q);
  assign cnt_x    = XW'(count_q);

  // command register
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q   <= cmd_i;
      pos_q   <= position_i;
      value_q <= value_i;
    end
  end

  // decode, range checks and cell control
  always_comb begin
    ctrl     = '0;
    ctrl.pos = pos_q;
    count_d  = count_q;
    stat_d   = iida_pkg::STAT_OK;
    if (state_q == iida_pkg::ST_EXEC) begin
      unique case (cmd_q)
        iida_pkg::CMD_CLEAR: begin
          count_d = '0;
        end
        iida_pkg::CMD_INSERT: begin
          if (count_q == CapC) begin
            stat_d = iida_pkg::STAT_FULL;
          end else if (pos_x > cnt_x) begin
            stat_d = iida_pkg::STAT_BADIDX;
          end else begin
            ctrl.ins = 1'b1;
            count_d  = count_q + CW'(1);
          end
        end
        iida_pkg::CMD_EDIT: begin
          if (pos_x >= cnt_x) begin
            stat_d = iida_pkg::STAT_BADIDX;
          end else begin
            ctrl.wr = 1'b1;
          end
        end
        iida_pkg::CMD_DELETE: begin
          if (pos_x >= cnt_x) begin
            stat_d = iida_pkg::STAT_BADIDX;
          end else begin
            ctrl.del = 1'b1;
            count_d  = count_q - CW'(1);
          end
        end
        iida_pkg::CMD_READ: begin
          if (pos_x >= cnt_x) begin
            stat_d = iida_pkg::STAT_BADIDX;
          end else begin
            ctrl.rd = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // sequencer
  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    unique case (state_q)
      iida_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          state_d = iida_pkg::ST_EXEC;
        end
      end
      iida_pkg::ST_EXEC: begin
        state_d = iida_pkg::ST_REDUCE;
      end
      iida_pkg::ST_REDUCE: begin
        if (out_free) begin
          state_d = iida_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = iida_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= iida_pkg::ST_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == iida_pkg::ST_EXEC) begin
      stat_q <= stat_d;
    end
  end

  // row of cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [iida_pkg::WordW-1:0] left, right;
    if (i == 0) begin : g_first
      assign left = '0;
    end else begin : g_mid_l
      assign left = words[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right = '0;
    end else begin : g_mid_r
      assign right = words[i+1];
    end
    iida_cell #(
      .Idx(i)
    ) u_cell (
      .clk_i    (clk_i),
      .ctrl_i   (ctrl),
      .value_i  (value_q),
      .left_i   (left),
      .right_i  (right),
      .word_o   (words[i]),
      .rd_word_o(rd_words[i])
    );
  end

  // read or tree
  iida_reduce #(
    .Capacity(CAPACITY)
  ) u_reduce (
    .clk_i  (clk_i),
    .load_i (state_q == iida_pkg::ST_EXEC),
    .words_i(rd_words),
    .word_o (red_word)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((state_q == iida_pkg::ST_REDUCE) && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == iida_pkg::ST_REDUCE) && out_free) begin
      out_stat_q <= stat_q;
      out_data_q <= red_word;
      out_fill_q <= FW'(count_q);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = out_stat_q;
  assign read_data_o  = out_data_q;
  assign fill_count_o = out_fill_q;

endmodule

// ===== src/iida_cell.sv =====
module iida_cell #(
  parameter int unsigned Idx = 0
) (
  input  logic                          clk_i,
  input  iida_pkg::cell_ctrl_t          ctrl_i,
  input  logic [iida_pkg::WordW-1:0]    value_i,
  input  logic [iida_pkg::WordW-1:0]    left_i,
  input  logic [iida_pkg::WordW-1:0]    right_i,
  output logic [iida_pkg::WordW-1:0]    word_o,
  output logic [iida_pkg::WordW-1:0]    rd_word_o
);

  localparam int unsigned XW = ($clog2(Idx + 1) > iida_pkg::PosW) ?
                               $clog2(Idx + 1) : iida_pkg::PosW;
  localparam logic [XW-1:0] IdxX = XW'(Idx);

  logic [iida_pkg::WordW-1:0] word_q, word_d;
  logic [XW-1:0]              pos_x;
  logic                       hit, above;

  // position relative to this cell
  assign pos_x = XW'(ctrl_i.pos);
  assign hit   = (pos_x == IdxX);
  assign above = (IdxX > pos_x);

  // shift up, shift down or overwrite
  always_comb begin
    word_d = word_q;
    if ((ctrl_i.ins || ctrl_i.wr) && hit) begin
      word_d = value_i;
    end else if (ctrl_i.ins && above) begin
      word_d = left_i;
    end else if (ctrl_i.del && (above || hit)) begin
      word_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign word_o    = word_q;
  assign rd_word_o = (ctrl_i.rd && hit) ? word_q : '0;

endmodule

// ===== src/iida_reduce.sv =====
module iida_reduce #(
  parameter int unsigned Capacity = iida_pkg::Capacity
) (
  input  logic                                      clk_i,
  input  logic                                      load_i,
  input  logic [Capacity-1:0][iida_pkg::WordW-1:0]  words_i,
  output logic [iida_pkg::WordW-1:0]                word_o
);

  localparam int unsigned Grp = iida_pkg::ReadGroup;
  localparam int unsigned NumGrp = (Capacity + Grp - 1) / Grp;

  logic [NumGrp-1:0][iida_pkg::WordW-1:0] grp_q, grp_d;

  // first level: or within each group, masked words are one-hot
  always_comb begin
    for (int unsigned g = 0; g < NumGrp; g++) begin
      grp_d[g] = '0;
      for (int unsigned j = 0; j < Grp; j++) begin
        if (g * Grp + j < Capacity) begin
          grp_d[g] = grp_d[g] | words_i[g * Grp + j];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      grp_q <= grp_d;
    end
  end

  // second level: or across groups
  always_comb begin
    word_o = '0;
    for (int unsigned g = 0; g < NumGrp; g++) begin
      word_o = word_o | grp_q[g];
    end
  end

endmodule

// ===== src/iida_checker.sv =====
module iida_checker #(
  parameter int unsigned CAPACITY = iida_pkg::Capacity
) (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_valid_i,
  input logic                               in_ready_o,
  input logic                               out_valid_o,
  input logic                               out_ready_i,
  input logic [iida_pkg::StatW-1:0]         status_o,
  input logic signed [iida_pkg::WordW-1:0]  read_data_o,
  input logic [iida_pkg::FillW-1:0]         fill_count_o
);

  // stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o) &&
      $stable(read_data_o) && $stable(fill_count_o))
    else $error("stalled result changed");

  // one command in flight at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request taken while busy");

  // failed commands return no data
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != iida_pkg::STAT_OK) |-> read_data_o == '0)
    else $error("data on failed request");

  // fill count within capacity, status a known code
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (32'(fill_count_o) <= CAPACITY) &&
      (status_o <= iida_pkg::STAT_BADIDX))
    else $error("bad fill count or status");

endmodule

bind indexed_insert_delete_array_core iida_checker #(
  .CAPACITY(CAPACITY)
) u_iida_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .status_o    (status_o),
  .read_data_o (read_data_o),
  .fill_count_o(fill_count_o)
);

// ===== tb/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Depth = iida_pkg::Capacity;
  localparam int NumRows = 26;
  localparam int RandomRequests = 2000;
  localparam int StallLimit = 1000;
  localparam int DrainCycles = 8;

  // command codes the block leaves unused
  localparam logic [iida_pkg::CmdW-1:0] CmdSpareLo = 3'd5;
  localparam logic [iida_pkg::CmdW-1:0] CmdSpareHi = 3'd7;

  typedef logic [iida_pkg::CmdW-1:0] cmd_bits_t;
  typedef logic [iida_pkg::PosW-1:0] pos_bits_t;

  typedef struct packed {
    logic [iida_pkg::StatW-1:0]        status;
    logic signed [iida_pkg::WordW-1:0] rdata;
    logic [iida_pkg::FillW-1:0]        fill;
  } array_reply_t;

  // one line of the directed script; append_n > 0 repeats an insert at the tail
  typedef struct {
    logic [iida_pkg::CmdW-1:0]         op;
    logic [iida_pkg::PosW-1:0]         pos;
    logic signed [iida_pkg::WordW-1:0] word;
    int                                append_n;
    bit                                typed;
    array_reply_t                      reply;
  } script_row_t;

  typedef enum {MIX_GROW, MIX_SHRINK, MIX_BLEND} traffic_e;

  logic                              clk_i = 1'b0;
  logic                              rst_ni = 1'b0;
  logic                              in_valid = 1'b0;
  logic                              in_ready;
  logic [iida_pkg::CmdW-1:0]         cmd = '0;
  logic [iida_pkg::PosW-1:0]         position = '0;
  logic signed [iida_pkg::WordW-1:0] value = '0;
  logic                              out_valid;
  logic                              out_ready = 1'b0;
  logic [iida_pkg::StatW-1:0]        status;
  logic signed [iida_pkg::WordW-1:0] read_data;
  logic [iida_pkg::FillW-1:0]        fill_count;

  // shadow copy of the array contents
  logic signed [iida_pkg::WordW-1:0] model_words [Depth];
  int                                model_fill = 0;

  array_reply_t            pending_replies [$];
  script_row_t             script [NumRows];
  int                      fail_count = 0;
  int                      idle_cycles = 0;
  bit                      no_idle = 1'b0;

  indexed_insert_delete_array_core i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .cmd_i        (cmd),
    .position_i   (position),
    .value_i      (value),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .status_o     (status),
    .read_data_o  (read_data),
    .fill_count_o (fill_count)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // apply one command to the shadow array and return its reply
  function automatic array_reply_t apply_array_op(logic [iida_pkg::CmdW-1:0] op,
                                                  logic [iida_pkg::PosW-1:0] pos,
                                                  logic signed [iida_pkg::WordW-1:0] word);
    array_reply_t r;
    int           idx;
    int           p;
    r.status = iida_pkg::STAT_OK;
    r.rdata  = '0;
    p = int'(pos);
    case (op)
      iida_pkg::CMD_CLEAR: model_fill = 0;
      iida_pkg::CMD_INSERT: begin
        if (model_fill >= Depth) begin
          r.status = iida_pkg::STAT_FULL;
        end else if (p > model_fill) begin
          r.status = iida_pkg::STAT_BADIDX;
        end else begin
          for (idx = model_fill; idx > p; idx--) model_words[idx] = model_words[idx-1];
          model_words[p] = word;
          model_fill++;
        end
      end
      iida_pkg::CMD_EDIT: begin
        if (p >= model_fill) r.status = iida_pkg::STAT_BADIDX;
        else model_words[p] = word;
      end
      iida_pkg::CMD_DELETE: begin
        if (p >= model_fill) begin
          r.status = iida_pkg::STAT_BADIDX;
        end else begin
          for (idx = p; idx + 1 < model_fill; idx++) model_words[idx] = model_words[idx+1];
          model_fill--;
        end
      end
      iida_pkg::CMD_READ: begin
        if (p >= model_fill) r.status = iida_pkg::STAT_BADIDX;
        else r.rdata = model_words[p];
      end
      default: ;
    endcase
    r.fill = model_fill[iida_pkg::FillW-1:0];
    return r;
  endfunction

  function automatic int idle_draw();
    return no_idle ? 0 : $urandom_range(0, 15);
  endfunction

  // extremes show up often, the rest is random
  function automatic logic signed [iida_pkg::WordW-1:0] draw_word();
    case ($urandom_range(0, 7))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return 32'sh0000_0000;
      3: return 32'shffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [iida_pkg::CmdW-1:0] pick_op(traffic_e m);
    int r;
    int ins_t;
    int rd_t;
    int ed_t;
    int del_t;
    r = $urandom_range(0, 99);
    case (m)
      MIX_GROW:   begin ins_t = 70; rd_t = 80; ed_t = 88; del_t = 95; end
      MIX_SHRINK: begin ins_t = 15; rd_t = 35; ed_t = 45; del_t = 90; end
      default:    begin ins_t = 30; rd_t = 60; ed_t = 75; del_t = 95; end
    endcase
    if (r < ins_t) return iida_pkg::CMD_INSERT;
    if (r < rd_t) return iida_pkg::CMD_READ;
    if (r < ed_t) return iida_pkg::CMD_EDIT;
    if (r < del_t) return iida_pkg::CMD_DELETE;
    case ($urandom_range(0, 3))
      0: return (m == MIX_GROW) ? CmdSpareLo : iida_pkg::CMD_CLEAR;
      1: return CmdSpareLo;
      2: return CmdSpareHi;
      default: return cmd_bits_t'($urandom_range(0, 7));
    endcase
  endfunction

  function automatic logic [iida_pkg::PosW-1:0] pick_pos(logic [iida_pkg::CmdW-1:0] op);
    if ($urandom_range(0, 9) == 0) return pos_bits_t'($urandom_range(0, 255));
    if (op == iida_pkg::CMD_INSERT) return pos_bits_t'($urandom_range(0, model_fill));
    if (model_fill > 0) return pos_bits_t'($urandom_range(0, model_fill - 1));
    return pos_bits_t'($urandom_range(0, 255));
  endfunction

  // present one request and hold it until taken, then queue the reply it should get
  task automatic send_request(logic [iida_pkg::CmdW-1:0] op, logic [iida_pkg::PosW-1:0] pos,
                              logic signed [iida_pkg::WordW-1:0] word, bit typed,
                              array_reply_t typed_reply);
    int           gap;
    array_reply_t r;
    gap = idle_draw();
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid <= 1'b1;
    cmd      <= op;
    position <= pos;
    value    <= word;
    do @(posedge clk_i); while (!in_ready);
    r = apply_array_op(op, pos, word);
    pending_replies.push_back(typed ? typed_reply : r);
  endtask

  // reply checker
  always @(posedge clk_i) begin : check_replies
    array_reply_t want;
    if (rst_ni && out_valid && out_ready) begin
      if (pending_replies.size() == 0) begin
        $display("%0t: unexpected reply status=%0d read_data=%0d fill=%0d",
                 $time, status, read_data, fill_count);
        fail_count++;
      end else begin
        want = pending_replies.pop_front();
        if (status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, status);
          fail_count++;
        end
        if (read_data !== want.rdata) begin
          $display("%0t: read_data expected %0d actual %0d", $time, want.rdata, read_data);
          fail_count++;
        end
        if (fill_count !== want.fill) begin
          $display("%0t: fill_count expected %0d actual %0d", $time, want.fill, fill_count);
          fail_count++;
        end
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= StallLimit) begin
        $display("FAIL indexed_insert_delete_array_core");
        $finish;
      end
    end
  end

  // result side back-pressure
  initial begin : drain_results
    int stall;
    wait (rst_ni);
    forever begin
      stall = idle_draw();
      if (stall > 0) begin
        @(negedge clk_i);
        out_ready <= 1'b0;
        repeat (stall - 1) @(negedge clk_i);
      end
      @(negedge clk_i);
      out_ready <= 1'b1;
      do @(posedge clk_i); while (!out_valid);
    end
  end

  initial begin : stimulus
    int       n;
    int       k;
    traffic_e mode;
    logic [iida_pkg::CmdW-1:0] op;

    script = '{
      '{iida_pkg::CMD_READ, 8'd0, 32'sd0, 0, 1'b1, '{iida_pkg::STAT_BADIDX, 32'sd0, 8'd0}},
      '{iida_pkg::CMD_DELETE, 8'd0, 32'sd0, 0, 1'b1, '{iida_pkg::STAT_BADIDX, 32'sd0, 8'd0}},
      '{iida_pkg::CMD_EDIT, 8'd0, 32'sd1234, 0, 1'b1, '{iida_pkg::STAT_BADIDX, 32'sd0, 8'd0}},
      '{iida_pkg::CMD_INSERT, 8'd1, 32'sd5, 0, 1'b1, '{iida_pkg::STAT_BADIDX, 32'sd0, 8'd0}},
      '{iida_pkg::CMD_INSERT, 8'd0, 32'sh8000_0000, 0, 1'b1,
        '{iida_pkg::STAT_OK, 32'sd0, 8'd1}},
      '{iida_pkg::CMD_READ, 8'd0, 32'sd0, 0, 1'b1,
        '{iida_pkg::STAT_OK, 32'sh8000_0000, 8'd1}},
      '{iida_pkg::CMD_INSERT, 8'd0, 32'sh7fff_ffff, 0, 1'b1,
        '{iida_pkg::STAT_OK, 32'sd0, 8'd2}},
      '{iida_pkg::CMD_INSERT, 8'd2, 32'shffff_ffff, 0, 1'b1,
        '{iida_pkg::STAT_OK, 32'sd0, 8'd3}},
      '{iida_pkg::CMD_INSERT, 8'd1, 32'sd0, 0, 1'b0, '{iida_pkg::STAT_OK, 32'sd0, 8'd0}},
      '{iida_pkg::CMD_READ, 8'd1, 32'sd0, 0, 1'b0, '{iida_pkg::STAT_OK, 32'sd0, 8'd0}},
      '{iida_pkg::CMD_READ, 8'd3, 32'sd0, 0, 1'b0, '{iida_pkg::STAT_OK, 32'sd0, 8'd0}},
      '{iida_pkg::CMD_EDIT, 8'd2, 32'sh5555_5555, 0, 1'b0,
        '{iida_pkg::STAT_OK, 32'sd0, 8'd0}},
      '{iida_pkg::CMD_READ, 8'd2, 32'sd0, 0, 1'b0, '{iida_pkg::STAT_OK, 32'sd0, 8'd0}},
      '{iida_pkg::CMD_DELETE, 8'd0, 32'sd0, 0, 1'b0, '{iida_pkg::STAT_OK, 32'sd0, 8'd0}},
      '{iida_pkg::CMD_READ, 8'd0, 32'sd0, 0, 1'b0, '{iida_pkg::STAT_OK, 32'sd0, 8'd0}},
      '{CmdSpareLo, 8'd255, 32'shffff_ffff, 0, 1'b1, '{iida_pkg::STAT_OK, 32'sd0, 8'd3}},
      '{CmdSpareHi, 8'd0, 32'sd0, 0, 1'b0, '{iida_pkg::STAT_OK, 32'sd0, 8'd0}},
      '{iida_pkg::CMD_DELETE, 8'd255, 32'sd0, 0, 1'b1,
        '{iida_pkg::STAT_BADIDX, 32'sd0, 8'd3}},
      '{iida_pkg::CMD_CLEAR, 8'd200, 32'sd0, 0, 1'b1, '{iida_pkg::STAT_OK, 32'sd0, 8'd0}},
      '{iida_pkg::CMD_INSERT, 8'd0, 32'sd0, Depth, 1'b0, '{iida_pkg::STAT_OK, 32'sd0, 8'd0}},
      '{iida_pkg::CMD_INSERT, 8'd0, 32'sd7, 0, 1'b1, '{iida_pkg::STAT_FULL, 32'sd0, 8'd128}},
      '{iida_pkg::CMD_INSERT, 8'd255, 32'sd7, 0, 1'b1,
        '{iida_pkg::STAT_FULL, 32'sd0, 8'd128}},
      '{iida_pkg::CMD_READ, 8'd127, 32'sd0, 0, 1'b0, '{iida_pkg::STAT_OK, 32'sd0, 8'd0}},
      '{iida_pkg::CMD_DELETE, 8'd127, 32'sd0, 0, 1'b0, '{iida_pkg::STAT_OK, 32'sd0, 8'd0}},
      '{iida_pkg::CMD_READ, 8'd127, 32'sd0, 0, 1'b1,
        '{iida_pkg::STAT_BADIDX, 32'sd0, 8'd127}},
      '{iida_pkg::CMD_EDIT, 8'd0, 32'shaaaa_aaaa, 0, 1'b0,
        '{iida_pkg::STAT_OK, 32'sd0, 8'd0}}
    };

    // hold reset at the start, then release it
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed script; appended rows fill the array from its tail
    for (n = 0; n < NumRows; n++) begin
      if (script[n].append_n > 0) begin
        for (k = 0; k < script[n].append_n; k++)
          send_request(script[n].op, model_fill[iida_pkg::PosW-1:0], draw_word(), 1'b0,
                       script[n].reply);
      end else begin
        send_request(script[n].op, script[n].pos, script[n].word, script[n].typed,
                     script[n].reply);
      end
    end

    // random traffic in segments that grow, shrink or mix the array
    mode = MIX_BLEND;
    for (n = 0; n < RandomRequests; n++) begin
      if (n % 64 == 0) begin
        mode    = traffic_e'($urandom_range(0, 2));
        no_idle = ($urandom_range(0, 3) == 0);
      end
      op = pick_op(mode);
      send_request(op, pick_pos(op), draw_word(), 1'b0, '0);
    end

    @(negedge clk_i);
    in_valid <= 1'b0;

    // drain outstanding replies, then a short quiet period
    while (pending_replies.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("PASS indexed_insert_delete_array_core");
    end else begin
      $display("FAIL indexed_insert_delete_array_core");
    end
    $finish;
  end

endmodule
